[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on i_clk, off while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TDSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TDSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/tdsc_pkg.sv]
// ----------------------------------------------------------------------------
// tdsc_pkg
// types, constants and helpers of the touch debounce and scale block
// ----------------------------------------------------------------------------
package tdsc_pkg;

    // field widths
    localparam int RAW_W    = 10;
    localparam int PRES_W   = 12;
    localparam int SIZE_W   = 11;
    localparam int PIX_W    = 10;
    localparam int CNT_W    = 8;
    localparam int NUM_W    = 20;
    localparam int QUO_W    = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int DATA_W   = 32;

    // debounce window length
    localparam logic [CNT_W-1:0] STABLE_SAMPLES = 8'd10;

    // register reset values
    localparam logic [PRES_W-1:0] RST_THRESHOLD = 12'd1750;
    localparam logic [RAW_W-1:0]  RST_X_LOW     = 10'd121;
    localparam logic [RAW_W-1:0]  RST_X_HIGH    = 10'd559;
    localparam logic [RAW_W-1:0]  RST_Y_LOW     = 10'd460;
    localparam logic [RAW_W-1:0]  RST_Y_HIGH    = 10'd975;
    localparam logic [SIZE_W-1:0] RST_WIDTH     = 11'd400;
    localparam logic [SIZE_W-1:0] RST_HEIGHT    = 11'd240;
    localparam logic              RST_MIRROR    = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_X_LOW     = 3'd1,
        CFG_X_HIGH    = 3'd2,
        CFG_Y_LOW     = 3'd3,
        CFG_Y_HIGH    = 3'd4,
        CFG_WIDTH     = 3'd5,
        CFG_HEIGHT    = 3'd6,
        CFG_MIRROR    = 3'd7
    } t_cfg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    // axis under work
    typedef enum logic {
        AXIS_X = 1'b0,
        AXIS_Y = 1'b1
    } t_axis;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [RAW_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quo;
    } t_div_rsp;

    // size of zero acts as one, sizes above the maximum are clipped
    function automatic logic [SIZE_W-1:0] fix_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0) begin
            r = 11'd1;
        end else if (s > SIZE_MAX) begin
            r = SIZE_MAX;
        end else begin
            r = s;
        end
        return r;
    endfunction

endpackage

[design/tdsc_div.sv]
// ----------------------------------------------------------------------------
// tdsc_div
// restoring serial divider, one quotient bit per cycle, 20 by 10 bits
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdsc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdsc_pkg::t_div_req i_req,
    output tdsc_pkg::t_div_rsp o_rsp
);
    import tdsc_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'(QUO_W - 1);

    logic               r_busy;
    logic [3:0]         r_cnt;
    logic [RAW_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_low;
    logic [RAW_W-1:0]   r_den;

    logic [RAW_W:0]     trial;
    logic               ge;
    logic [RAW_W:0]     diff;
    logic [RAW_W-1:0]   rem_nxt;
    logic [QUO_W-1:0]   low_nxt;

    // one trial subtraction
    assign trial   = {r_rem, r_low[QUO_W-1]};
    assign ge      = trial >= {1'b0, r_den};
    assign diff    = trial - {1'b0, r_den};
    assign rem_nxt = ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
    assign low_nxt = {r_low[QUO_W-2:0], ge};

    assign o_rsp.done = r_busy && (r_cnt == LAST_STEP);
    assign o_rsp.quo  = low_nxt;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= (r_cnt != LAST_STEP);
            r_cnt  <= r_cnt + 4'd1;
        end
    end

    // datapath: quotient bits shift into the low word
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {1'b0, i_req.num[NUM_W-1:QUO_W]};
            r_low <= i_req.num[QUO_W-1:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= rem_nxt;
            r_low <= low_nxt;
        end
    end

    `TDSC_ASSERT_IMP(a_div_cnt_bound, r_busy, r_cnt <= LAST_STEP, "divider step count overran")
    `TDSC_ASSERT_IMP(a_div_rem_below, r_busy, r_rem < r_den, "divider remainder not below divisor")
    `TDSC_ASSERT_NXT(a_div_stop, o_rsp.done && !i_req.start, !r_busy, "divider busy after last step")

endmodule

[design/touch_debounce_and_scale.sv]
// ----------------------------------------------------------------------------
// touch_debounce_and_scale
// debounces resistive touch samples and maps pressed positions to pixels
// ----------------------------------------------------------------------------
// channel  | dir | handshake            | payload
// s        | in  | i_s_tvalid/o_s_tready| tdata: raw_x, raw_y, raw_pressure
// m        | out | o_m_tvalid/i_m_tready| tdata: screen_x, screen_y, pressure_out;
//          |     |                      | tuser: touched
// cfg      | in  | i_cfg_wr_en          | i_cfg_idx, i_cfg_data
//
// a word that ends no window is only accepted; a released result is accepted, then
// the done state loads the output
// a pressed result goes through the accept, then per axis a multiply state and 11 steps
// of the shared serial divider, then the done state loads the output
// a full output register that is not taken holds the sequencer in its last state
// reset is synchronous, active low; config resets to the default calibration
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_debounce_and_scale (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // raw_x [9:0], raw_y [19:10], raw_pressure [31:20]
    input  logic [tdsc_pkg::DATA_W-1:0]          i_s_tdata,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // screen_x [9:0], screen_y [19:10], pressure_out [31:20]
    output logic [tdsc_pkg::DATA_W-1:0]          o_m_tdata,
    // touched [0]
    output logic                                 o_m_tuser,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic                                 i_cfg_wr_en,
    input  logic [tdsc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tdsc_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import tdsc_pkg::*;

    // configuration registers
    logic [PRES_W-1:0] r_thr;
    logic [RAW_W-1:0]  r_x_lo, r_x_hi, r_y_lo, r_y_hi;
    logic [SIZE_W-1:0] r_width, r_height;
    logic              r_mirror;

    // sequencer and debounce state
    t_state            r_state, n_state;
    t_axis             r_axis;
    logic [CNT_W-1:0]  r_count;
    logic              r_last;

    // captured word and results
    logic [RAW_W-1:0]  r_rx, r_ry;
    logic [PRES_W-1:0] r_rp;
    logic              r_touch;
    logic [PIX_W-1:0]  r_sx, r_sy;

    // output register
    logic              r_ov;
    logic              r_otouch;
    logic [DATA_W-1:0] r_odata;

    t_div_req          div_req;
    t_div_rsp          div_rsp;

    logic [RAW_W-1:0]  in_x, in_y;
    logic [PRES_W-1:0] in_p;
    logic              accept, pressed, window_end;
    logic [CNT_W-1:0]  cnt_nxt;

    logic [RAW_W-1:0]  ax_raw, ax_lo, ax_hi, ax_clamp, ax_diff;
    logic [SIZE_W-1:0] ax_size;
    logic              ax_empty;
    logic [NUM_W-1:0]  ax_prod;
    logic [PIX_W-1:0]  size_m1, q_sat, q_fin;
    logic              out_free;

    assign in_x = i_s_tdata[RAW_W-1:0];
    assign in_y = i_s_tdata[2*RAW_W-1:RAW_W];
    assign in_p = i_s_tdata[2*RAW_W+PRES_W-1:2*RAW_W];

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_ov || i_m_tready;

    // debounce decision for the incoming word
    assign pressed    = in_p < r_thr;
    assign cnt_nxt    = (pressed == r_last) ? r_count + 8'd1 : '0;
    assign window_end = cnt_nxt >= STABLE_SAMPLES;

    // axis operand selection, clamp and scale
    always_comb begin
        if (r_axis == AXIS_Y) begin
            ax_raw  = r_ry;
            ax_lo   = r_y_lo;
            ax_hi   = r_y_hi;
            ax_size = fix_size(r_height);
        end else begin
            ax_raw  = r_rx;
            ax_lo   = r_x_lo;
            ax_hi   = r_x_hi;
            ax_size = fix_size(r_width);
        end
        ax_empty = ax_hi <= ax_lo;
        if (ax_raw < ax_lo) begin
            ax_clamp = ax_lo;
        end else if (ax_raw > ax_hi) begin
            ax_clamp = ax_hi;
        end else begin
            ax_clamp = ax_raw;
        end
        ax_diff = ax_clamp - ax_lo;
        // at most 1023 * 1024, fits the 20-bit numerator
        ax_prod = NUM_W'(ax_diff) * NUM_W'(ax_size);
        size_m1 = PIX_W'(ax_size - 11'd1);
    end

    // divider request: an empty span divides zero by one
    assign div_req.start = (r_state == ST_MUL);
    assign div_req.num   = ax_empty ? '0 : ax_prod;
    assign div_req.den   = ax_empty ? RAW_W'(1) : ax_hi - ax_lo;

    tdsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // saturate the quotient, and mirror it on the x axis when mirroring is set
    always_comb begin
        if (div_rsp.quo > {1'b0, size_m1}) begin
            q_sat = size_m1;
        end else begin
            q_sat = div_rsp.quo[PIX_W-1:0];
        end
        if (r_axis == AXIS_X && r_mirror) begin
            q_fin = size_m1 - q_sat;
        end else begin
            q_fin = q_sat;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && window_end) begin
                    n_state = pressed ? ST_MUL : ST_DONE;
                end
            end
            ST_MUL: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = (r_axis == AXIS_Y) ? ST_DONE : ST_MUL;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= RST_THRESHOLD;
            r_x_lo   <= RST_X_LOW;
            r_x_hi   <= RST_X_HIGH;
            r_y_lo   <= RST_Y_LOW;
            r_y_hi   <= RST_Y_HIGH;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_mirror <= RST_MIRROR;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_thr    <= i_cfg_data;
                CFG_X_LOW:     r_x_lo   <= i_cfg_data[RAW_W-1:0];
                CFG_X_HIGH:    r_x_hi   <= i_cfg_data[RAW_W-1:0];
                CFG_Y_LOW:     r_y_lo   <= i_cfg_data[RAW_W-1:0];
                CFG_Y_HIGH:    r_y_hi   <= i_cfg_data[RAW_W-1:0];
                CFG_WIDTH:     r_width  <= i_cfg_data[SIZE_W-1:0];
                CFG_HEIGHT:    r_height <= i_cfg_data[SIZE_W-1:0];
                CFG_MIRROR:    r_mirror <= i_cfg_data[0];
                default:       r_mirror <= r_mirror;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= AXIS_X;
            r_count <= '0;
            r_last  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_axis <= AXIS_X;
                if (window_end) begin
                    r_count <= '0;
                    r_last  <= 1'b0;
                end else begin
                    r_count <= cnt_nxt;
                    r_last  <= pressed;
                end
            end else if (r_state == ST_DIV && div_rsp.done) begin
                r_axis <= AXIS_Y;
            end
            if (r_state == ST_DONE && out_free) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // captured word and per-axis results
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rx    <= in_x;
            r_ry    <= in_y;
            r_rp    <= pressed ? in_p : '0;
            r_touch <= pressed;
            r_sx    <= '0;
            r_sy    <= '0;
        end else if (r_state == ST_DIV && div_rsp.done) begin
            if (r_axis == AXIS_Y) begin
                r_sy <= q_fin;
            end else begin
                r_sx <= q_fin;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_otouch <= r_touch;
            r_odata  <= {r_rp, r_sy, r_sx};
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_otouch;
    assign o_m_tdata  = r_odata;

    `TDSC_ASSERT_IMP(a_count_below, 1'b1, r_count < STABLE_SAMPLES, "debounce count reached window")
    `TDSC_ASSERT_IMP(a_div_in_div, div_rsp.done, r_state == ST_DIV, "divider finished outside division")
    `TDSC_ASSERT_IMP(a_release_zero, r_ov && !r_otouch, r_odata == '0, "released word has data")
    `TDSC_ASSERT_NXT(a_y_to_done, r_state == ST_DIV && div_rsp.done && r_axis == AXIS_Y, r_state == ST_DONE, "second axis did not finish")

endmodule

[test/touch_debounce_and_scale_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_debounce_and_scale_tb
// streams touch samples through the debounce and scale block over several
// calibration settings and idle patterns, predicts every window report from
// a cycle-free model of the debounce counter and the axis mapping, and
// compares each report field by field in order of arrival
// ----------------------------------------------------------------------------
module touch_debounce_and_scale_tb;
    import tdsc_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_WAIT  = 40;
    localparam int PHASE_WORDS  = 80;

    typedef struct packed {
        logic              touched;
        logic [PIX_W-1:0]  sx;
        logic [PIX_W-1:0]  sy;
        logic [PRES_W-1:0] pres;
    } t_touch_report;

    // block ports
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic [DATA_W-1:0]    i_s_tdata   = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [DATA_W-1:0]    o_m_tdata;
    logic                 o_m_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data  = '0;

    // calibration copy
    logic [PRES_W-1:0] thr_q    = RST_THRESHOLD;
    logic [RAW_W-1:0]  xlo_q    = RST_X_LOW;
    logic [RAW_W-1:0]  xhi_q    = RST_X_HIGH;
    logic [RAW_W-1:0]  ylo_q    = RST_Y_LOW;
    logic [RAW_W-1:0]  yhi_q    = RST_Y_HIGH;
    logic [SIZE_W-1:0] width_q  = RST_WIDTH;
    logic [SIZE_W-1:0] height_q = RST_HEIGHT;
    logic              mirror_q = RST_MIRROR;

    // debounce state copy
    logic [CNT_W-1:0]  win_count    = '0;
    logic              held_pressed = 1'b0;

    logic [DATA_W-1:0] samples_q[$];
    t_touch_report     touch_reports_q[$];

    int  samples_queued = 0;
    int  samples_sent   = 0;
    int  n_pressed      = 0;
    int  n_released     = 0;
    int  n_settings     = 1;
    int  mismatches     = 0;
    int  cycles         = 0;
    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    logic s_took = 1'b0;

    touch_debounce_and_scale dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // screen size of zero acts as one, above the maximum it is clipped
    function automatic logic [SIZE_W-1:0] clip_span(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = 11'd1;
        end else if (s > 11'd1024) begin
            r = 11'd1024;
        end
        return r;
    endfunction

    // clamp to the span, scale, truncate, saturate to the last pixel; an empty span gives zero
    function automatic logic [PIX_W-1:0] pixel_of(input logic [RAW_W-1:0] raw,
                                                  input logic [RAW_W-1:0] lo,
                                                  input logic [RAW_W-1:0] hi,
                                                  input logic [SIZE_W-1:0] span);
        int unsigned c;
        int unsigned v;
        if (hi <= lo) begin
            return '0;
        end
        c = raw;
        if (raw < lo) begin
            c = lo;
        end else if (raw > hi) begin
            c = hi;
        end
        v = ((c - lo) * span) / (hi - lo);
        if (v > span - 1) begin
            v = span - 1;
        end
        return PIX_W'(v);
    endfunction

    // advance the debounce window by one sample, queue the report it closes
    task automatic debounce_and_map(input logic [RAW_W-1:0] rx,
                                    input logic [RAW_W-1:0] ry,
                                    input logic [PRES_W-1:0] rp);
        t_touch_report     rep;
        logic              pressed;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        logic [PIX_W-1:0]  px;
        pressed = rp < thr_q;
        if (pressed == held_pressed) begin
            win_count = win_count + 8'd1;
        end else begin
            win_count    = '0;
            held_pressed = pressed;
        end
        if (win_count >= STABLE_SAMPLES) begin
            rep = '0;
            if (pressed) begin
                w  = clip_span(width_q);
                h  = clip_span(height_q);
                px = pixel_of(rx, xlo_q, xhi_q, w);
                if (mirror_q) begin
                    px = PIX_W'(w - 11'd1 - px);
                end
                rep.touched = 1'b1;
                rep.sx      = px;
                rep.sy      = pixel_of(ry, ylo_q, yhi_q, h);
                rep.pres    = rp;
            end
            touch_reports_q.push_back(rep);
            win_count    = '0;
            held_pressed = 1'b0;
        end
    endtask

    task automatic compare_field(input string what, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // sample acceptance, report checking and the run limit
    always @(posedge i_clk) begin : watch
        t_touch_report want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d reports outstanding", $time,
                     touch_reports_q.size());
            $display("** touch_debounce_and_scale: FAILED **");
            $finish;
        end else begin
            s_took <= i_rst_n && i_s_tvalid && o_s_tready;
            if (i_rst_n && i_s_tvalid && o_s_tready) begin
                samples_sent++;
                debounce_and_map(i_s_tdata[9:0], i_s_tdata[19:10], i_s_tdata[31:20]);
            end
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (o_m_tuser) begin
                    n_pressed++;
                end else begin
                    n_released++;
                end
                if (touch_reports_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected report: expected none, %s%0d x=%0d y=%0d p=%0d",
                             $time, "got touched=", o_m_tuser, o_m_tdata[9:0],
                             o_m_tdata[19:10], o_m_tdata[31:20]);
                end else begin
                    want = touch_reports_q.pop_front();
                    compare_field("touched", want.touched, o_m_tuser);
                    compare_field("screen_x", want.sx, o_m_tdata[9:0]);
                    compare_field("screen_y", want.sy, o_m_tdata[19:10]);
                    compare_field("pressure_out", want.pres, o_m_tdata[31:20]);
                end
            end
        end
    end

    // sample driver and sink ready, both on the falling edge
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_took) begin
            if (samples_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                i_s_tdata  <= samples_q.pop_front();
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // register write, only while the block is drained
    task automatic set_reg(input t_cfg_idx idx, input int unsigned val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_data  <= CFG_DAT_W'(val);
        case (idx)
            CFG_THRESHOLD: thr_q    = PRES_W'(val);
            CFG_X_LOW:     xlo_q    = RAW_W'(val);
            CFG_X_HIGH:    xhi_q    = RAW_W'(val);
            CFG_Y_LOW:     ylo_q    = RAW_W'(val);
            CFG_Y_HIGH:    yhi_q    = RAW_W'(val);
            CFG_WIDTH:     width_q  = SIZE_W'(val);
            CFG_HEIGHT:    height_q = SIZE_W'(val);
            CFG_MIRROR:    mirror_q = val[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_all(input int unsigned thr, input int unsigned xl,
                           input int unsigned xh, input int unsigned yl,
                           input int unsigned yh, input int unsigned w,
                           input int unsigned h, input int unsigned mir);
        set_reg(CFG_THRESHOLD, thr);
        set_reg(CFG_X_LOW, xl);
        set_reg(CFG_X_HIGH, xh);
        set_reg(CFG_Y_LOW, yl);
        set_reg(CFG_Y_HIGH, yh);
        set_reg(CFG_WIDTH, w);
        set_reg(CFG_HEIGHT, h);
        set_reg(CFG_MIRROR, mir);
        n_settings++;
    endtask

    task automatic add_sample(input int unsigned x, input int unsigned y,
                              input int unsigned p);
        samples_q.push_back({PRES_W'(p), RAW_W'(y), RAW_W'(x)});
        samples_queued++;
    endtask

    // half full range, half inside the calibrated span
    function automatic int unsigned pick_raw(input logic [RAW_W-1:0] lo,
                                             input logic [RAW_W-1:0] hi);
        if ($urandom_range(0, 1)) begin
            return $urandom_range(0, 1023);
        end
        return $urandom_range(lo, hi);
    endfunction

    function automatic int unsigned press_level();
        if (thr_q == '0) begin
            return $urandom_range(0, 4095);
        end
        return $urandom_range(0, thr_q - 1);
    endfunction

    task automatic press_run(input int n);
        repeat (n) begin
            add_sample(pick_raw(xlo_q, xhi_q), pick_raw(ylo_q, yhi_q), press_level());
        end
    endtask

    task automatic release_run(input int n);
        repeat (n) begin
            add_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                       $urandom_range(thr_q, 4095));
        end
    endtask

    // mostly full windows, some cut short, some pure noise
    task automatic queue_gestures(input int n);
        int stop;
        int kind;
        stop = samples_queued + n;
        while (samples_queued < stop) begin
            kind = $urandom_range(0, 99);
            if (kind < 50) begin
                press_run($urandom_range(11, 24));
            end else if (kind < 72) begin
                release_run($urandom_range(10, 20));
            end else if (kind < 80) begin
                press_run($urandom_range(1, 9));
            end else if (kind < 86) begin
                release_run($urandom_range(1, 8));
            end else begin
                repeat ($urandom_range(1, 5)) begin
                    add_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                               $urandom_range(0, 4095));
                end
            end
        end
    endtask

    // sender holds off until every report is back, then the block settles
    task automatic wait_drained();
        while (samples_sent != samples_queued || touch_reports_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic run_phase(input int mode, input int n);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
            default: begin src_idle_pct = 26; sink_stall_pct = 26; end
        endcase
        queue_gestures(n);
        wait_drained();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: clamp at the low end, then a window decided by pressure equal to the
        // threshold, then clamp at the high end with saturation, all with mirroring
        press_run(10);
        add_sample(0, 0, 0);
        repeat (10) add_sample($urandom_range(0, 1023), $urandom_range(0, 1023), 1750);
        press_run(10);
        add_sample(1023, 1023, 1749);
        run_phase(0, PHASE_WORDS);

        // widest spans and largest screen, no mirror
        set_all(4095, 0, 1023, 0, 1023, 1024, 1024, 0);
        run_phase(1, PHASE_WORDS);

        // empty spans, zero width, oversize height
        set_all(2048, 500, 500, 900, 100, 0, 2047, 1);
        run_phase(2, PHASE_WORDS);

        // zero threshold: nothing counts as pressed
        set_all(0, 121, 559, 460, 975, 400, 240, 1);
        run_phase(3, PHASE_WORDS);

        // random calibration
        set_all($urandom_range(1, 4095), $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 2047),
                $urandom_range(0, 2047), $urandom_range(0, 1));
        run_phase(0, PHASE_WORDS);

        // one-step spans, single-pixel width, height just above the maximum
        set_all(1, 1022, 1023, 0, 1, 1, 1025, 1);
        run_phase(1, PHASE_WORDS);

        // random calibration with ordered spans
        set_all($urandom_range(1024, 4095), $urandom_range(0, 400), $urandom_range(401, 1023),
                $urandom_range(0, 400), $urandom_range(401, 1023), $urandom_range(1, 1024),
                $urandom_range(1, 1024), $urandom_range(0, 1));
        run_phase(2, PHASE_WORDS);

        $display("run covered %0d touch samples over %0d calibration settings,", samples_sent,
                 n_settings);
        $display("giving %0d pressed and %0d released reports", n_pressed, n_released);
        if (mismatches == 0) begin
            $display("** touch_debounce_and_scale: PASSED **");
        end else begin
            $display("** touch_debounce_and_scale: FAILED **");
        end
        $finish;
    end

endmodule
